/* hw/rtl/tufc_pkg.sv */
// Shared types, codes and constants of the threshold union-find connectivity core.
`timescale 1ns / 1ps

package tufc_pkg;

	// Default node capacity of the forest memories.
	localparam int MAX_NODES_DEF = 1024;

	// Fixed field widths of the stream words and registers.
	localparam int VALUE_W   = 32;
	localparam int NODE_W    = 10;
	localparam int MAXDIFF_W = 31;
	localparam int NCOUNT_W  = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	// Reset value of the node count register.
	localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Request codes carried in the input tuser.
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

	// Command from the request decoder to the forest engine.
	typedef struct packed {
		logic start;  // run two finds on node1 and node2
		logic unite;  // after the finds, join the two sets
		logic clear;  // sweep the forest back to single-node sets
	} tufc_cmd_t;

	// Status from the forest engine.
	typedef struct packed {
		logic busy;   // sweeping or working on a command
		logic done;   // one-cycle pulse when a find or union command finishes
		logic same;   // both finds ended at the same root
	} tufc_stat_t;

endpackage

/* hw/rtl/threshold_union_find_connectivity_core.sv */
// Top level of the threshold union-find connectivity core: stream ports, registers, decode.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: value, node_a, node_b; tuser: req_type
// m_axis    out  m_axis_tvalid/tready        tdata: connected, index_error
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// A clear sweeps every node back to a single-node set; the same sweep follows reset and
// no word is accepted before it ends. A query runs a find on each node, walking its links
// to the root and then compressing that path; the registered parent read walks one link
// a cycle. A joining add runs the same finds and then the union; other adds and a query
// out of range leave the engine idle. A result waits in the output register while the
// next word is accepted; a later query holds in its emit step until that register is free.
module threshold_union_find_connectivity_core import tufc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tdata fields from bit 0: value[31:0], node_a[41:32], node_b[51:42], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser fields from bit 0: req_type[1:0]
	input  logic [1:0]            s_axis_tuser,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata fields from bit 0: connected[0], index_error[1], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);
	localparam int KW = (SW > NCOUNT_W) ? SW : NCOUNT_W;

	// Decoder state codes.
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_DEC  = 2'd1;
	localparam logic [1:0] T_RUN  = 2'd2;
	localparam logic [1:0] T_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic [MAXDIFF_W-1:0] max_diff_q;
	logic [NCOUNT_W-1:0]  node_count_q;
	logic [KW-1:0]        loaded_q;
	logic [VALUE_W-1:0]   prev_q;
	logic [1:0]           req_q;
	logic [VALUE_W-1:0]   val_q;
	logic [NODE_W-1:0]    a_q;
	logic [NODE_W-1:0]    b_q;
	logic                 conn_q;
	logic                 err_q;
	logic                 m_valid_q;
	logic [1:0]           m_data_q;

	logic [KW-1:0]        nc_ext;
	logic [KW-1:0]        active;
	logic [KW-1:0]        loaded_m1;
	logic [KW-1:0]        a_ext;
	logic [KW-1:0]        b_ext;
	logic                 q_error;
	logic                 full;
	logic signed [VALUE_W:0] diff;
	logic                 join_ok;
	logic                 s_fire;
	logic                 emit;
	tufc_cmd_t            cmd;
	tufc_stat_t           stat;
	logic [NW-1:0]        node1;
	logic [NW-1:0]        node2;

	tufc_forest #(
		.MAX_NODES(MAX_NODES)
	) u_forest (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.node1 (node1),
		.node2 (node2),
		.stat  (stat)
	);

	// Count in force and range checks.
	assign nc_ext    = KW'(node_count_q);
	assign active    = (nc_ext < KW'(MAX_NODES)) ? nc_ext : KW'(MAX_NODES);
	assign loaded_m1 = loaded_q - KW'(1);
	assign a_ext     = KW'(a_q);
	assign b_ext     = KW'(b_q);
	assign q_error   = (a_ext >= active) || (b_ext >= active);
	assign full      = (loaded_q >= active);

	// Step between neighbouring values, one bit wider so it cannot overflow.
	assign diff    = $signed({val_q[VALUE_W-1], val_q}) - $signed({prev_q[VALUE_W-1], prev_q});
	assign join_ok = diff[VALUE_W] || (diff[VALUE_W-1:0] <= {1'b0, max_diff_q});

	assign s_axis_tready = (state_q == T_IDLE) && !stat.busy;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// The output register takes a result when it is empty or being read.
	assign emit = (state_q == T_EMIT) && (!m_valid_q || m_axis_tready);

	// Command to the forest engine, issued from the decode cycle.
	always_comb begin
		cmd   = '0;
		node1 = a_ext[NW-1:0];
		node2 = b_ext[NW-1:0];
		if (state_q == T_DEC) begin
			case (req_q)
				REQ_CLEAR: begin
					cmd.clear = 1'b1;
				end
				REQ_ADD: begin
					node1 = loaded_m1[NW-1:0];
					node2 = loaded_q[NW-1:0];
					if (!full && loaded_q != '0 && join_ok) begin
						cmd.start = 1'b1;
						cmd.unite = 1'b1;
					end
				end
				REQ_QUERY: begin
					cmd.start = !q_error;
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q   <= '0;
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_DIFF:   max_diff_q   <= cfg_data[MAXDIFF_W-1:0];
				CFG_NODE_COUNT: node_count_q <= cfg_data[NCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_q <= s_axis_tuser;
			val_q <= s_axis_tdata[VALUE_W-1:0];
			a_q   <= s_axis_tdata[VALUE_W +: NODE_W];
			b_q   <= s_axis_tdata[VALUE_W + NODE_W +: NODE_W];
		end
	end

	// Request sequencer, load position and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			loaded_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {err_q, conn_q};
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (s_fire) begin
						state_q <= T_DEC;
					end
				end
				T_DEC: begin
					case (req_q)
						REQ_CLEAR: begin
							loaded_q <= '0;
							state_q  <= T_IDLE;
						end
						REQ_ADD: begin
							if (!full) begin
								prev_q   <= val_q;
								loaded_q <= loaded_q + KW'(1);
							end
							state_q <= cmd.start ? T_RUN : T_IDLE;
						end
						REQ_QUERY: begin
							if (q_error) begin
								conn_q  <= 1'b0;
								err_q   <= 1'b1;
								state_q <= T_EMIT;
							end else begin
								state_q <= T_RUN;
							end
						end
						default: begin
							state_q <= T_IDLE;
						end
					endcase
				end
				T_RUN: begin
					if (stat.done) begin
						conn_q  <= stat.same;
						err_q   <= 1'b0;
						state_q <= (req_q == REQ_QUERY) ? T_EMIT : T_IDLE;
					end
				end
				T_EMIT: begin
					if (emit) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, m_data_q};

	// The engine is only started while it is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start || cmd.clear) |-> !stat.busy)
		else $error("command issued to a busy engine");

	// The load position never passes the capacity.
	a_loaded_cap: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= KW'(MAX_NODES))
		else $error("load position beyond capacity");

	// An engine completion is only seen while waiting for it.
	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == T_RUN))
		else $error("engine done outside of run state");

endmodule

/* hw/rtl/tufc_forest.sv */
// Forest engine: parent and size memories with a find, compress and unite sequencer.
`timescale 1ns / 1ps

module tufc_forest import tufc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tufc_cmd_t                    cmd,
	input  logic [$clog2(MAX_NODES)-1:0] node1,
	input  logic [$clog2(MAX_NODES)-1:0] node2,
	output tufc_stat_t                   stat
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);

	// Sequencer state codes.
	localparam logic [3:0] E_CLR  = 4'd0;
	localparam logic [3:0] E_IDLE = 4'd1;
	localparam logic [3:0] E_FRD  = 4'd2;
	localparam logic [3:0] E_FCHK = 4'd3;
	localparam logic [3:0] E_CCHK = 4'd4;
	localparam logic [3:0] E_CWR  = 4'd5;
	localparam logic [3:0] E_NEXT = 4'd6;
	localparam logic [3:0] E_SZ1  = 4'd7;
	localparam logic [3:0] E_SZ2  = 4'd8;
	localparam logic [3:0] E_SZ3  = 4'd9;

	logic [3:0]    state_q;
	logic [NW-1:0] clr_idx_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] start_q;
	logic [NW-1:0] root_q;
	logic [NW-1:0] root1_q;
	logic [NW-1:0] node2_q;
	logic          second_q;
	logic          unite_q;
	logic          done_q;
	logic          same_q;
	logic [SW-1:0] size1_q;

	// Forest memories, one write and one registered read port each.
	logic [NW-1:0] parent_mem [MAX_NODES];
	logic [SW-1:0] size_mem   [MAX_NODES];
	logic [NW-1:0] par_rd_q;
	logic [SW-1:0] size_rd_q;

	logic [NW-1:0] par_raddr;
	logic [NW-1:0] par_waddr;
	logic [NW-1:0] par_wdata;
	logic          par_we;
	logic [NW-1:0] sz_raddr;
	logic [NW-1:0] sz_waddr;
	logic [SW-1:0] sz_wdata;
	logic          sz_we;
	logic          link_mismatch;
	logic          small_first;
	logic [SW-1:0] size_sum;
	logic          cmd_end;

	// The shared compare: does the link read back point away from the node?
	assign link_mismatch = (par_rd_q != cur_q);
	assign small_first   = (size1_q < size_rd_q);
	assign size_sum      = size1_q + size_rd_q;

	// A command ends after the second find when no union follows, or after the union.
	assign cmd_end = (state_q == E_SZ3) ||
		(state_q == E_NEXT && second_q && !(unite_q && root1_q != root_q));

	// Read addresses: while walking up, the link just read is the next node.
	always_comb begin
		par_raddr = cur_q;
		if (state_q == E_FCHK && link_mismatch) begin
			par_raddr = par_rd_q;
		end
		sz_raddr = (state_q == E_SZ2) ? root_q : root1_q;
	end

	// Write ports: clearing sweep, path compression and the union link.
	always_comb begin
		par_we    = 1'b0;
		par_waddr = cur_q;
		par_wdata = root_q;
		sz_we     = 1'b0;
		sz_waddr  = root1_q;
		sz_wdata  = size_sum;
		case (state_q)
			E_CLR: begin
				par_we    = 1'b1;
				par_waddr = clr_idx_q;
				par_wdata = clr_idx_q;
				sz_we     = 1'b1;
				sz_waddr  = clr_idx_q;
				sz_wdata  = SW'(1);
			end
			E_CWR: begin
				par_we = 1'b1;
			end
			E_SZ3: begin
				par_we = 1'b1;
				sz_we  = 1'b1;
				if (small_first) begin
					par_waddr = root1_q;
					par_wdata = root_q;
					sz_waddr  = root_q;
				end else begin
					par_waddr = root_q;
					par_wdata = root1_q;
					sz_waddr  = root1_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			parent_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= parent_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (sz_we) begin
			size_mem[sz_waddr] <= sz_wdata;
		end
		size_rd_q <= size_mem[sz_raddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_CLR;
			clr_idx_q <= '0;
			second_q  <= 1'b0;
			unite_q   <= 1'b0;
			done_q    <= 1'b0;
			same_q    <= 1'b0;
		end else begin
			done_q <= cmd_end;
			case (state_q)
				E_CLR: begin
					clr_idx_q <= clr_idx_q + NW'(1);
					if (clr_idx_q == NW'(MAX_NODES - 1)) begin
						state_q <= E_IDLE;
					end
				end
				E_IDLE: begin
					if (cmd.clear) begin
						clr_idx_q <= '0;
						state_q   <= E_CLR;
					end else if (cmd.start) begin
						cur_q    <= node1;
						start_q  <= node1;
						node2_q  <= node2;
						unite_q  <= cmd.unite;
						second_q <= 1'b0;
						state_q  <= E_FRD;
					end
				end
				E_FRD: begin
					state_q <= E_FCHK;
				end
				E_FCHK: begin
					if (link_mismatch) begin
						cur_q <= par_rd_q;
					end else begin
						root_q  <= cur_q;
						cur_q   <= start_q;
						state_q <= E_CCHK;
					end
				end
				E_CCHK: begin
					state_q <= (cur_q == root_q) ? E_NEXT : E_CWR;
				end
				E_CWR: begin
					cur_q   <= par_rd_q;
					state_q <= E_CCHK;
				end
				E_NEXT: begin
					if (!second_q) begin
						root1_q  <= root_q;
						second_q <= 1'b1;
						cur_q    <= node2_q;
						start_q  <= node2_q;
						state_q  <= E_FRD;
					end else if (unite_q && root1_q != root_q) begin
						state_q <= E_SZ1;
					end else begin
						same_q  <= (root1_q == root_q);
						state_q <= E_IDLE;
					end
				end
				E_SZ1: begin
					state_q <= E_SZ2;
				end
				E_SZ2: begin
					size1_q <= size_rd_q;
					state_q <= E_SZ3;
				end
				E_SZ3: begin
					same_q  <= 1'b0;
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != E_IDLE);
	assign stat.done = done_q;
	assign stat.same = same_q;

	// Done is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");

	// Compression never rewrites the root itself.
	a_comp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_CWR) |-> (cur_q != root_q))
		else $error("compression write at the root");

	// A union only links two distinct roots.
	a_unite_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_SZ3) |-> (root1_q != root_q))
		else $error("union of a root with itself");

	// The size memory changes only during the sweep or a union.
	a_size_write: assert property (@(posedge clk) disable iff (!arst_n)
		sz_we |-> (state_q == E_CLR || state_q == E_SZ3))
		else $error("size write outside sweep or union");

endmodule
